// ----- design/slc_pkg.sv -----
// Shared types, codes and constants of the scalar literal classifier.
package slc_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned INT_W   = 64;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned TDATA_W = 72;
  localparam int unsigned MAG_W   = INT_W;
  localparam int unsigned ACC_W   = INT_W + 4;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_E  = 8'h45;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_E  = 8'h65;
  localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
  localparam logic [CHAR_W-1:0] CH_LO_L  = 8'h6C;
  localparam logic [CHAR_W-1:0] CH_LO_R  = 8'h72;
  localparam logic [CHAR_W-1:0] CH_LO_S  = 8'h73;
  localparam logic [CHAR_W-1:0] CH_LO_T  = 8'h74;
  localparam logic [CHAR_W-1:0] CH_LO_U  = 8'h75;

  // 2^63 in the accumulator width: largest magnitude kept.
  localparam logic [ACC_W-1:0] ACC_LIMIT = ACC_W'(1) << (INT_W - 1);

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_INT_OVFL = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_TEXT    = 2'd0,
    KIND_BOOLEAN = 2'd1,
    KIND_INTEGER = 2'd2,
    KIND_DECIMAL = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    G_START    = 4'd0,
    G_SIGN     = 4'd1,
    G_INT      = 4'd2,
    G_POINT_D  = 4'd3,
    G_POINT    = 4'd4,
    G_FRAC     = 4'd5,
    G_EXP      = 4'd6,
    G_EXP_SIGN = 4'd7,
    G_EXP_DIG  = 4'd8,
    G_REJECT   = 4'd9
  } gram_state_t;

  typedef enum logic [3:0] {
    W_START = 4'd0,
    W_T     = 4'd1,
    W_TR    = 4'd2,
    W_TRU   = 4'd3,
    W_TRUE  = 4'd4,
    W_F     = 4'd5,
    W_FA    = 4'd6,
    W_FAL   = 4'd7,
    W_FALS  = 4'd8,
    W_FALSE = 4'd9,
    W_DEAD  = 4'd15
  } word_state_t;

  typedef struct packed {
    kind_t             kind;
    logic              flag_value;
    logic [INT_W-1:0]  int_value;
    logic              status;
  } result_t;

endpackage

// ----- design/scalar_literal_classifier.sv -----
// Top level of the scalar literal classifier: stream ports, input and result registers.
// The block reads a scalar value one byte per transaction, ended by a zero byte, and on
// that terminator sends one result transaction classifying it: boolean for exactly
// "true" or "false", integer for an optionally signed digit string (value in two's
// complement, status flags a value outside the signed 64-bit range, which then reads
// as text), decimal for digits with a fraction and/or exponent, text otherwise. A byte
// is accepted every cycle unless a terminator waits in the input register: it lands in an
// input register and then updates the recognizer state, and a terminator's result is written
// to the result register once that register is free. Throughput is one byte per cycle while no
// terminator waits; the multiply-by-ten accumulate of the integer magnitude is combinational.
// Only a stalled result register holds back a terminator, which then blocks further bytes.
module scalar_literal_classifier (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [slc_pkg::CHAR_W-1:0]    in_tdata,   // [7:0] character
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [slc_pkg::TDATA_W-1:0]   out_tdata,  // [0] flag_value, [64:1] int_value,
                                                    // [65] status, [71:66] zero
  output logic [slc_pkg::KIND_W-1:0]    out_tuser   // [1:0] kind
);

  logic [slc_pkg::CHAR_W-1:0] char_r;
  logic                       char_vld_r, char_vld_nxt;
  logic                       out_vld_r, out_vld_nxt;
  slc_pkg::result_t           res_r;
  slc_pkg::result_t           res_calc;
  logic                       out_free, step, emit, in_acc;

  // A terminator may only advance when the result register can take its result
  assign out_free  = !out_vld_r || out_tready;
  assign step      = char_vld_r && ((char_r != slc_pkg::CH_NUL) || out_free);
  assign emit      = step && (char_r == slc_pkg::CH_NUL);
  assign in_tready = !char_vld_r || step;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    char_vld_nxt = char_vld_r;
    if (in_acc) char_vld_nxt = 1'b1;
    else if (step) char_vld_nxt = 1'b0;
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (emit) out_vld_nxt = 1'b1;
    else if (out_tready) out_vld_nxt = 1'b0;
  end

  slc_parse u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step),
    .char_i (char_r),
    .res_o  (res_calc)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      char_vld_r <= char_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Payload: capture the byte on accept, hold the result until taken
  always_ff @(posedge clk) begin
    if (in_acc) char_r <= in_tdata;
    if (emit) res_r <= res_calc;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = res_r.kind;
  assign out_tdata  = {6'b0, res_r.status, res_r.int_value, res_r.flag_value};

endmodule

// ----- design/slc_parse.sv -----
// Keyword matcher, decimal grammar recognizer and integer accumulator.
module slc_parse (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step_i,
  input  logic [slc_pkg::CHAR_W-1:0]   char_i,
  output slc_pkg::result_t             res_o
);

  slc_pkg::gram_state_t        gram_r, gram_nxt;
  slc_pkg::word_state_t        word_r, word_nxt;
  logic                        neg_r, neg_nxt;
  logic [slc_pkg::MAG_W-1:0]   mag_r, mag_nxt;
  logic                        ovfl_r, ovfl_nxt;

  logic                        is_digit, is_sign, is_exp, is_point, is_end;
  logic                        acc_en;
  logic [slc_pkg::ACC_W-1:0]   acc_sum;

  assign is_digit = (char_i >= slc_pkg::CH_ZERO) && (char_i <= slc_pkg::CH_NINE);
  assign is_sign  = (char_i == slc_pkg::CH_PLUS) || (char_i == slc_pkg::CH_MINUS);
  assign is_exp   = (char_i == slc_pkg::CH_LO_E) || (char_i == slc_pkg::CH_UP_E);
  assign is_point = (char_i == slc_pkg::CH_POINT);
  assign is_end   = (char_i == slc_pkg::CH_NUL);

  // 10*m + d as (m << 3) + (m << 1) + d; never wraps since m <= 2^63
  assign acc_sum = ({4'b0, mag_r} << 3) + ({4'b0, mag_r} << 1)
                 + {{(slc_pkg::ACC_W-4){1'b0}}, char_i[3:0]};

  // Keyword matcher
  always_comb begin
    unique case (word_r)
      slc_pkg::W_START: begin
        if (char_i == slc_pkg::CH_LO_T) word_nxt = slc_pkg::W_T;
        else if (char_i == slc_pkg::CH_LO_F) word_nxt = slc_pkg::W_F;
        else word_nxt = slc_pkg::W_DEAD;
      end
      slc_pkg::W_T:    word_nxt = (char_i == slc_pkg::CH_LO_R) ? slc_pkg::W_TR : slc_pkg::W_DEAD;
      slc_pkg::W_TR:   word_nxt = (char_i == slc_pkg::CH_LO_U) ? slc_pkg::W_TRU : slc_pkg::W_DEAD;
      slc_pkg::W_TRU:  word_nxt = (char_i == slc_pkg::CH_LO_E) ? slc_pkg::W_TRUE : slc_pkg::W_DEAD;
      slc_pkg::W_F:    word_nxt = (char_i == slc_pkg::CH_LO_A) ? slc_pkg::W_FA : slc_pkg::W_DEAD;
      slc_pkg::W_FA:   word_nxt = (char_i == slc_pkg::CH_LO_L) ? slc_pkg::W_FAL : slc_pkg::W_DEAD;
      slc_pkg::W_FAL:  word_nxt = (char_i == slc_pkg::CH_LO_S) ? slc_pkg::W_FALS : slc_pkg::W_DEAD;
      slc_pkg::W_FALS: word_nxt = (char_i == slc_pkg::CH_LO_E) ? slc_pkg::W_FALSE : slc_pkg::W_DEAD;
      default:         word_nxt = slc_pkg::W_DEAD;
    endcase
  end

  // Grammar recognizer; a digit of a plain optionally signed digit string feeds the accumulator
  always_comb begin
    neg_nxt = neg_r;
    acc_en  = 1'b0;
    unique case (gram_r)
      slc_pkg::G_START, slc_pkg::G_SIGN: begin
        if (gram_r == slc_pkg::G_START && is_sign) begin
          neg_nxt  = (char_i == slc_pkg::CH_MINUS);
          gram_nxt = slc_pkg::G_SIGN;
        end else if (is_digit) begin
          acc_en   = 1'b1;
          gram_nxt = slc_pkg::G_INT;
        end else begin
          gram_nxt = is_point ? slc_pkg::G_POINT : slc_pkg::G_REJECT;
        end
      end
      slc_pkg::G_INT: begin
        if (is_digit) begin
          acc_en   = 1'b1;
          gram_nxt = slc_pkg::G_INT;
        end else if (is_point) begin
          gram_nxt = slc_pkg::G_POINT_D;
        end else begin
          gram_nxt = is_exp ? slc_pkg::G_EXP : slc_pkg::G_REJECT;
        end
      end
      slc_pkg::G_POINT_D, slc_pkg::G_FRAC: begin
        if (is_digit) gram_nxt = slc_pkg::G_FRAC;
        else gram_nxt = is_exp ? slc_pkg::G_EXP : slc_pkg::G_REJECT;
      end
      slc_pkg::G_POINT:
        gram_nxt = is_digit ? slc_pkg::G_FRAC : slc_pkg::G_REJECT;
      slc_pkg::G_EXP: begin
        if (is_sign) gram_nxt = slc_pkg::G_EXP_SIGN;
        else gram_nxt = is_digit ? slc_pkg::G_EXP_DIG : slc_pkg::G_REJECT;
      end
      slc_pkg::G_EXP_SIGN, slc_pkg::G_EXP_DIG:
        gram_nxt = is_digit ? slc_pkg::G_EXP_DIG : slc_pkg::G_REJECT;
      default:
        gram_nxt = slc_pkg::G_REJECT;
    endcase
  end

  // Accumulate; the overflow flag is sticky and freezes the magnitude
  always_comb begin
    mag_nxt  = mag_r;
    ovfl_nxt = ovfl_r;
    if (acc_en && !ovfl_r) begin
      if (acc_sum > slc_pkg::ACC_LIMIT) ovfl_nxt = 1'b1;
      else mag_nxt = acc_sum[slc_pkg::MAG_W-1:0];
    end
  end

  // Result, meaningful when the terminator is presented
  always_comb begin
    res_o.kind       = slc_pkg::KIND_TEXT;
    res_o.flag_value = 1'b0;
    res_o.int_value  = '0;
    res_o.status     = slc_pkg::STATUS_OK;
    if (word_r == slc_pkg::W_TRUE) begin
      res_o.kind       = slc_pkg::KIND_BOOLEAN;
      res_o.flag_value = 1'b1;
    end else if (word_r == slc_pkg::W_FALSE) begin
      res_o.kind = slc_pkg::KIND_BOOLEAN;
    end else if (gram_r == slc_pkg::G_INT) begin
      if (ovfl_r || (!neg_r && mag_r[slc_pkg::MAG_W-1])) begin
        res_o.status = slc_pkg::STATUS_INT_OVFL;
      end else begin
        res_o.kind      = slc_pkg::KIND_INTEGER;
        res_o.int_value = neg_r ? (slc_pkg::MAG_W'(0) - mag_r) : mag_r;
      end
    end else if (gram_r == slc_pkg::G_POINT_D || gram_r == slc_pkg::G_FRAC ||
                 gram_r == slc_pkg::G_EXP_DIG) begin
      res_o.kind = slc_pkg::KIND_DECIMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step_i && is_end)) begin
      gram_r <= slc_pkg::G_START;
      word_r <= slc_pkg::W_START;
      neg_r  <= 1'b0;
      mag_r  <= '0;
      ovfl_r <= 1'b0;
    end else if (step_i) begin
      gram_r <= gram_nxt;
      word_r <= word_nxt;
      neg_r  <= neg_nxt;
      mag_r  <= mag_nxt;
      ovfl_r <= ovfl_nxt;
    end
  end

endmodule

// ----- design/slc_checker.sv -----
// Port-level checks of the scalar literal classifier, bound to the top level.
module slc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [slc_pkg::TDATA_W-1:0]  out_tdata,
  input logic [slc_pkg::KIND_W-1:0]   out_tuser
);

  // Reset empties the input and result registers
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid && in_tready)
    else $error("registers not empty after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Integer value is zero unless the kind is integer
  a_int_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != slc_pkg::KIND_INTEGER) |-> (out_tdata[64:1] == '0))
    else $error("int_value set for non-integer kind");

  // Overflow status only on text; true flag only on boolean
  a_status_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[65] |-> (out_tuser == slc_pkg::KIND_TEXT) && !out_tdata[0])
    else $error("overflow status on non-text result");

  a_flag_bool: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> (out_tuser == slc_pkg::KIND_BOOLEAN))
    else $error("flag_value set on non-boolean result");

endmodule

bind scalar_literal_classifier slc_checker u_slc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
